// File: hw/rtl/stvp_pkg.sv
// Shared types and constants for the segmented trapezoid velocity profile core.
package stvp_pkg;

  // Item kinds carried on in_tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_SEGMENT_COUNT = 1'b0;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SEG_IDX_W  = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // in_tdata field offsets
  localparam int unsigned IN_IDX_LSB  = 0;
  localparam int unsigned IN_VEL_LSB  = 4;
  localparam int unsigned IN_ACC_LSB  = 36;
  localparam int unsigned IN_DUR_LSB  = 68;
  localparam int unsigned IN_TIME_LSB = 100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_MUL_UP,
    S_FINISH
  } stvp_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] velocity;
    logic [VAL_W-1:0] accel;
    logic [VAL_W-1:0] duration;
  } stvp_seg_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic             go;
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] mult;
  } stvp_mul_req_t;

endpackage

// File: hw/rtl/stvp_mul.sv
// Shared scaled multiplier: magnitude times time, floor-scaled and saturated.
module stvp_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk,
  input  stvp_pkg::stvp_mul_req_t     req,
  output logic signed [stvp_pkg::VAL_W-1:0] result
);
  import stvp_pkg::*;

  localparam logic [63:0] RND = 64'((64'd1 << FRAC_BITS) - 64'd1);

  logic [63:0] prod_r;
  logic        neg_r;
  logic [63:0] sum;
  logic [63:0] q;

  // Hold the product until the next request
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= 64'(req.mag) * 64'(req.mult);
      neg_r  <= req.neg;
    end
  end

  // Negative products round toward minus infinity
  always_comb begin
    sum = neg_r ? (prod_r + RND) : prod_r;
    q   = sum >> FRAC_BITS;
    if (!neg_r) begin
      result = (|q[63:31]) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      result = (q > 64'h8000_0000) ? 32'sh8000_0000 : $signed(~q[31:0] + 32'd1);
    end
  end

endmodule

// File: hw/rtl/segmented_trapezoid_velocity_profile_core.sv
// Top level: segment store, walk sequencer and result register of the velocity profile core.
// Flow: a query holds off the next transfer until its walk and multiplier passes are done and
//   its result is written to the result register, which waits while out_tready is low and the
//   register is full; loads are taken one per cycle. The walk reads one segment per cycle
//   through the table read port. An in-range query then makes two passes through the single
//   shared multiplier; a query whose time lies past the reached segment skips them.
// Reset: rst_n is synchronous, active low; it idles the sequencer, empties the result
//   register and sets segment_count to 1. Segment tables are not cleared.
module segmented_trapezoid_velocity_profile_core #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] seg_index, [35:4] seg_velocity, [67:36] seg_accel, [99:68] seg_duration,
  // [131:100] query_time, [135:132] zero
  input  logic [stvp_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] cmd
  input  logic                                in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] velocity, [35:32] segment_used, [39:36] zero
  output logic [stvp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] past_end
  output logic                                out_tuser,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stvp_pkg::PADDR_W-1:0]        paddr,
  input  logic [stvp_pkg::PDATA_W-1:0]        pwdata,
  output logic [stvp_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import stvp_pkg::*;

  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [8:0]  MAX_N = 9'(MAX_SEGMENTS);

  // Input field unpacking
  logic [SEG_IDX_W-1:0] in_seg_index;
  logic [VAL_W-1:0]     in_query_time;
  stvp_seg_t            in_seg;

  assign in_seg_index   = in_tdata[IN_IDX_LSB +: SEG_IDX_W];
  assign in_seg.velocity = in_tdata[IN_VEL_LSB +: VAL_W];
  assign in_seg.accel    = in_tdata[IN_ACC_LSB +: VAL_W];
  assign in_seg.duration = in_tdata[IN_DUR_LSB +: VAL_W];
  assign in_query_time  = in_tdata[IN_TIME_LSB +: VAL_W];

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] seg_count_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SEGMENT_COUNT);
  assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? PDATA_W'(seg_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= COUNT_W'(1);
    end else if (cfg_wr) begin
      seg_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // Effective count: zero acts as one, large values clamp to the table depth
  logic [8:0] cnt9;
  logic [8:0] n_eff;

  assign cnt9  = 9'(seg_count_r);
  assign n_eff = (cnt9 == 9'd0) ? 9'd1 : ((cnt9 > MAX_N) ? MAX_N : cnt9);

  // ---------------------------------------------------------------------------
  // Segment table: one write port for loads, one registered read port for the walk
  // ---------------------------------------------------------------------------
  stvp_seg_t        seg_mem [MAX_SEGMENTS];
  stvp_seg_t        rd_seg_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             idx_ok;

  assign wr_addr = IDX_W'(in_seg_index);
  assign idx_ok  = (9'(in_seg_index) < MAX_N);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr] <= in_seg;
    end
  end

  always_ff @(posedge clk) begin
    rd_seg_r <= seg_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  stvp_mul_req_t            mul_req;
  logic signed [VAL_W-1:0]  mul_res;

  stvp_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .req    (mul_req),
    .result (mul_res)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  stvp_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [VAL_W-1:0]        t_r, t_nxt;
  logic [VAL_W-1:0]        dur_r, dur_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;
  logic                    past_r, past_nxt;
  logic signed [VAL_W-1:0] up_r, up_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]        out_vel_r, out_vel_nxt;
  logic [SEG_IDX_W-1:0]    out_seg_r, out_seg_nxt;
  logic                    out_past_r, out_past_nxt;

  logic                    more_segs;
  logic [VAL_W-1:0]        acc_src;
  logic [VAL_W-1:0]        acc_mag;
  logic                    pos_case;
  logic signed [VAL_W-1:0] mid;
  logic signed [VAL_W-1:0] res;

  assign more_segs = (9'(i_r) + 9'd1) < n_eff;

  // Magnitude of the acceleration: from the table during the walk, held afterwards
  assign acc_src = (state_r == S_WALK) ? rd_seg_r.accel : a_r;
  assign acc_mag = acc_src[VAL_W-1] ? (~acc_src + 32'd1) : acc_src;

  // Both positive: take the smallest term; otherwise the largest
  assign pos_case = (v_r > 32'sd0) && (a_r > 32'sd0);
  always_comb begin
    if (pos_case) begin
      mid = (up_r < mul_res) ? up_r : mul_res;
      res = (v_r < mid) ? v_r : mid;
    end else begin
      mid = (up_r > mul_res) ? up_r : mul_res;
      res = (v_r > mid) ? v_r : mid;
    end
  end

  // Read address tracks the next walk index so the table data lines up with i_r
  assign rd_addr = i_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    t_r        <= t_nxt;
    dur_r      <= dur_nxt;
    v_r        <= v_nxt;
    a_r        <= a_nxt;
    past_r     <= past_nxt;
    up_r       <= up_nxt;
    out_vel_r  <= out_vel_nxt;
    out_seg_r  <= out_seg_nxt;
    out_past_r <= out_past_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    t_nxt         = t_r;
    dur_nxt       = dur_r;
    v_nxt         = v_r;
    a_nxt         = a_r;
    past_nxt      = past_r;
    up_nxt        = up_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_vel_nxt   = out_vel_r;
    out_seg_nxt   = out_seg_r;
    out_past_nxt  = out_past_r;
    mul_req       = '0;
    wr_en         = 1'b0;
    in_tready     = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_LOAD) begin
            // Drop loads aimed beyond the table
            wr_en = idx_ok;
          end else begin
            i_nxt     = '0;
            t_nxt     = in_query_time;
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if ((rd_seg_r.duration < t_r) && more_segs) begin
          // Advance: consume this segment's duration
          t_nxt = t_r - rd_seg_r.duration;
          i_nxt = i_r + IDX_W'(1);
        end else begin
          dur_nxt  = rd_seg_r.duration;
          v_nxt    = $signed(rd_seg_r.velocity);
          a_nxt    = $signed(rd_seg_r.accel);
          past_nxt = (t_r > rd_seg_r.duration);
          if (t_r > rd_seg_r.duration) begin
            state_nxt = S_FINISH;
          end else begin
            // Rising term: acc * t
            mul_req.go   = 1'b1;
            mul_req.neg  = rd_seg_r.accel[VAL_W-1];
            mul_req.mag  = acc_mag;
            mul_req.mult = t_r;
            state_nxt    = S_MUL_UP;
          end
        end
      end

      S_MUL_UP: begin
        // Falling term: acc * (T - t)
        up_nxt       = mul_res;
        mul_req.go   = 1'b1;
        mul_req.neg  = a_r[VAL_W-1];
        mul_req.mag  = acc_mag;
        mul_req.mult = dur_r - t_r;
        state_nxt    = S_FINISH;
      end

      S_FINISH: begin
        // Hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_vel_nxt   = past_r ? '0 : res;
          out_seg_nxt   = SEG_IDX_W'(i_r);
          out_past_nxt  = past_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_seg_r, out_vel_r};
  assign out_tuser  = out_past_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (9'(i_r) < n_eff))
    else $error("walk index beyond segments in use");

  a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_QUERY)) |=>
      (state_r == S_WALK) && (i_r == '0))
    else $error("query did not start walk at segment zero");

  a_walk_steps_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && state_nxt == S_WALK) |=> (i_r == $past(i_r) + IDX_W'(1)))
    else $error("walk index did not advance by one");

  a_past_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_past_r) |-> (out_vel_r == '0))
    else $error("past-end result carries nonzero velocity");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the segmented trapezoid velocity profile core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stvp_pkg::*;

  localparam int     MAX_SEGMENTS = 16;
  localparam int     FRAC_BITS    = 16;
  localparam int     MAX_GAP      = 17;
  localparam int     LONG_HOLD    = 400;  // receiver hold-off used to back the block up
  localparam int     SETTLE       = 30;   // covers the longest walk plus margin
  localparam int     PHASE_ITEMS  = 150;
  localparam longint SAT_HI       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO       = -SAT_HI - 1;

  // One input transfer: a segment load or a velocity query
  typedef struct {
    logic        cmd;
    logic [3:0]  idx;
    logic [31:0] vel;
    logic [31:0] acc;
    logic [31:0] dur;
    logic [31:0] qtime;
  } profile_cmd_t;

  // One result transfer
  typedef struct {
    logic signed [31:0] velocity;
    logic [3:0]         seg;
    logic               past_end;
  } velocity_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [3:0] seg_index, [35:4] seg_velocity, [67:36] seg_accel, [99:68] seg_duration,
  // [131:100] query_time, [135:132] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [0] cmd
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  // [31:0] velocity, [35:32] segment_used, [39:36] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  // [0] past_end
  logic                  out_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  segmented_trapezoid_velocity_profile_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: segment tables and count as the block should hold them
  logic [31:0] vel_tbl [MAX_SEGMENTS];
  logic [31:0] acc_tbl [MAX_SEGMENTS];
  logic [31:0] dur_tbl [MAX_SEGMENTS];
  logic [4:0]  seg_count_q = 5'd1;

  // Planning copy of the durations, updated when an item is queued rather than
  // when it is accepted; only used to aim query times at segment boundaries
  logic [31:0] plan_dur [MAX_SEGMENTS];
  int          plan_segs = 1;

  profile_cmd_t cmd_backlog[$];
  velocity_t    expected_velocity_q[$];
  profile_cmd_t offered_cmd;
  int           queued_cmds = 0;
  int           accepted_cmds = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           send_wait = 0;
  bit           send_burst = 0;
  int           recv_hold = 0;
  bit           recv_burst = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #8_000_000;
    $display("segmented_trapezoid_velocity_profile_core test failed");
    $finish;
  end

  // Signed Q16.16 times unsigned Q16.16, floor-scaled and clamped to 32 bits
  function automatic logic signed [31:0] scale_product(logic signed [31:0] a, logic [31:0] u);
    longint prod;
    prod = longint'(a) * longint'({32'd0, u});
    prod = prod >>> FRAC_BITS;
    if (prod > SAT_HI) return 32'h7FFF_FFFF;
    if (prod < SAT_LO) return 32'h8000_0000;
    return prod[31:0];
  endfunction

  // Walk the segments in use and evaluate the trapezoid in the one reached
  function automatic velocity_t compute_velocity(logic [31:0] qtime);
    velocity_t          res;
    logic [31:0]        remain;
    logic [31:0]        span;
    logic signed [31:0] v;
    logic signed [31:0] a;
    logic signed [31:0] up;
    logic signed [31:0] down;
    logic signed [31:0] r;
    int                 last;
    int                 seg;
    // count of zero acts as one; counts past the table size clamp to it
    if (seg_count_q == 0) last = 0;
    else if (seg_count_q > MAX_SEGMENTS) last = MAX_SEGMENTS - 1;
    else last = seg_count_q - 1;
    remain = qtime;
    seg = 0;
    while (dur_tbl[seg] < remain && seg < last) begin
      remain -= dur_tbl[seg];
      seg++;
    end
    span = dur_tbl[seg];
    res.seg = seg[3:0];
    if (remain > span) begin
      res.velocity = '0;
      res.past_end = 1'b1;
      return res;
    end
    v = vel_tbl[seg];
    a = acc_tbl[seg];
    up = scale_product(a, remain);
    down = scale_product(a, span - remain);
    if (v > 0 && a > 0) begin
      r = (up < down) ? up : down;
      if (v < r) r = v;
    end else begin
      r = (up > down) ? up : down;
      if (v > r) r = v;
    end
    res.velocity = r;
    res.past_end = 1'b0;
    return res;
  endfunction

  // Input driver: offer queued items, hold while stalled, insert random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        // transfer accepted: update the predictor in arrival order
        if (offered_cmd.cmd == CMD_LOAD) begin
          vel_tbl[offered_cmd.idx] = offered_cmd.vel;
          acc_tbl[offered_cmd.idx] = offered_cmd.acc;
          dur_tbl[offered_cmd.idx] = offered_cmd.dur;
        end else begin
          expected_velocity_q.insert(expected_velocity_q.size(),
                                     compute_velocity(offered_cmd.qtime));
        end
        accepted_cmds++;
        // switch between gap-free bursts and idling now and then
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait == 0 && cmd_backlog.size() > 0) begin
          offered_cmd = cmd_backlog.pop_front();
          in_tdata  <= {4'd0, offered_cmd.qtime, offered_cmd.dur, offered_cmd.acc,
                        offered_cmd.vel, offered_cmd.idx};
          in_tuser  <= offered_cmd.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end
      end
    end
  end

  // Result monitor and receiver: check each transfer, then draw the next stall
  always @(posedge clk) begin
    velocity_t want;
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_velocity_q.size() == 0) begin
          $error("unexpected result: velocity %0d segment_used %0d past_end %0d",
                 $signed(out_tdata[31:0]), out_tdata[35:32], out_tuser);
          mismatches++;
        end else begin
          want = expected_velocity_q.pop_front();
          if (out_tdata[31:0] !== want.velocity) begin
            $error("velocity: expected %0d, got %0d", want.velocity, $signed(out_tdata[31:0]));
            mismatches++;
          end
          if (out_tdata[35:32] !== want.seg) begin
            $error("segment_used: expected %0d, got %0d", want.seg, out_tdata[35:32]);
            mismatches++;
          end
          if (out_tuser !== want.past_end) begin
            $error("past_end: expected %0d, got %0d", want.past_end, out_tuser);
            mismatches++;
          end
        end
        results_seen++;
        // one long hold-off lets the block fill up and stall its input
        if (results_seen == PHASE_ITEMS) begin
          recv_hold = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
          recv_hold = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      if (recv_hold > 0) begin
        out_tready <= 1'b0;
        recv_hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Time that lands `off` into segment k, assuming the planned durations
  function automatic logic [31:0] time_to(int k, longint off);
    longint sum;
    sum = off;
    for (int j = 0; j < k; j++) sum += plan_dur[j];
    return (sum > 64'sh0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = $urandom;
      4, 5, 6: begin
        val = $urandom_range(0, 32'h0006_0000);
        if ($urandom_range(0, 1) == 1) val = -val;
      end
      7: val = 32'h7FFF_FFFF;
      8: val = 32'h8000_0000;
      default: val = $urandom_range(0, 2) - 1;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] pick_duration();
    case ($urandom_range(0, 9))
      6: return 32'd0;
      7: return $urandom;
      8: return $urandom_range(1, 32'h0100_0000);
      9: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd1;
      default: return $urandom_range(1, 32'h0006_0000);
    endcase
  endfunction

  function automatic profile_cmd_t load_cmd(logic [3:0] idx, logic [31:0] vel,
                                            logic [31:0] acc, logic [31:0] dur);
    profile_cmd_t c;
    c.cmd = CMD_LOAD;
    c.idx = idx;
    c.vel = vel;
    c.acc = acc;
    c.dur = dur;
    c.qtime = $urandom;  // ignored on loads
    return c;
  endfunction

  function automatic profile_cmd_t query_cmd(logic [31:0] qtime);
    profile_cmd_t c;
    c = load_cmd(4'($urandom), $urandom, $urandom, $urandom);  // segment fields ignored
    c.cmd = CMD_QUERY;
    c.qtime = qtime;
    return c;
  endfunction

  task automatic queue_cmd(profile_cmd_t c);
    if (c.cmd == CMD_LOAD) plan_dur[c.idx] = c.dur;
    cmd_backlog.insert(cmd_backlog.size(), c);
    queued_cmds++;
  endtask

  // Mostly well-aimed queries, some loads, some unaimed times
  task automatic queue_random_cmd();
    int k;
    if ($urandom_range(0, 99) < 30) begin
      queue_cmd(load_cmd(4'($urandom_range(0, MAX_SEGMENTS - 1)), pick_value(), pick_value(),
                         pick_duration()));
    end else begin
      k = $urandom_range(0, plan_segs - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: queue_cmd(query_cmd(time_to(k, longint'($urandom_range(0, plan_dur[k])))));
        5: queue_cmd(query_cmd(time_to(k, longint'(plan_dur[k]))));
        6: queue_cmd(query_cmd(time_to(k, longint'(plan_dur[k]) + 1)));
        7: queue_cmd(query_cmd(time_to(plan_segs - 1,
                                       longint'(plan_dur[plan_segs - 1]) + 1 +
                                       $urandom_range(0, 32'hFFFF))));
        default: queue_cmd(query_cmd($urandom));
      endcase
    end
  endtask

  // Block until every queued item is in and every result is out, then settle
  task automatic wait_idle();
    while (accepted_cmds != queued_cmds || expected_velocity_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value on the last edge
  task automatic write_segment_count(logic [4:0] count);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SEGMENT_COUNT, 2'b00};
    pwdata  <= {27'($urandom_range(0, 32'h07FF_FFFF)), count};  // upper bits are ignored
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seg_count_q = count;
    if (count == 0) plan_segs = 1;
    else if (count > MAX_SEGMENTS) plan_segs = MAX_SEGMENTS;
    else plan_segs = count;
  endtask

  // Phase sequence: full chain, single segment, zero, too large, then assorted
  initial begin
    int counts [9];
    counts = '{16, 1, 0, 31, 17, 2, 9, 16, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      write_segment_count((ph == 8) ? 5'($urandom_range(0, 31)) : 5'(counts[ph]));
      if (ph == 0) begin
        // load every entry first, so no query ever reads an unwritten one
        queue_cmd(load_cmd(4'd0, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000));
        queue_cmd(load_cmd(4'd1, 32'hFFFD_0000, 32'hFFFE_8000, 32'h0006_0000));
        queue_cmd(load_cmd(4'd2, 32'h0001_8000, 32'hFFFF_0000, 32'h0003_0000));
        queue_cmd(load_cmd(4'd3, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000));
        for (int i = 4; i < 14; i++) begin
          queue_cmd(load_cmd(4'(i), (i % 2 == 1) ? 32'h0003_0000 : 32'hFFFF_8000,
                             (i % 3 == 0) ? -(i * 32'h4000) : i * 32'h4000,
                             32'h0002_0000 + i * 32'h1000));
        end
        // most negative velocity and acceleration: products clamp low
        queue_cmd(load_cmd(4'd14, 32'h8000_0000, 32'h8000_0000, 32'h0005_0000));
        // largest everything in the open-ended last entry: products clamp high
        queue_cmd(load_cmd(4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        queue_cmd(query_cmd(32'd0));
        queue_cmd(query_cmd(time_to(0, longint'(plan_dur[0]))));  // exactly at the end
        queue_cmd(query_cmd(time_to(1, 1)));                      // just into the next
        queue_cmd(query_cmd(time_to(3, 0)));                      // through zero duration
        queue_cmd(query_cmd(time_to(4, 32'h8000)));
        queue_cmd(query_cmd(time_to(9, longint'(plan_dur[9] / 2))));
        queue_cmd(query_cmd(time_to(14, 32'h0002_8000)));
        queue_cmd(query_cmd(time_to(15, 32'h1234_5678)));
        queue_cmd(query_cmd(32'hFFFF_FFFF));
      end
      repeat (PHASE_ITEMS) queue_random_cmd();
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("segmented_trapezoid_velocity_profile_core test passed");
    end else begin
      $display("segmented_trapezoid_velocity_profile_core test failed");
    end
    $finish;
  end

endmodule
